// ----- hw/rtl/llpq_pkg.sv -----
// Shared types for the linked list packet queue: request codes, FSM states, command/status.
package llpq_pkg;

	// request codes carried in a request word
	typedef enum logic [1:0] {
		REQ_START_WRITE  = 2'd0,
		REQ_FINISH_WRITE = 2'd1,
		REQ_START_READ   = 2'd2,
		REQ_FINISH_READ  = 2'd3
	} req_type_t;

	// controller states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_POP,
		ST_LINK,
		ST_FETCH
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic clr_en;       // write one entry of the link memories during the clearing pass
		logic start_pop;    // read free_next at the free head
		logic finish_pop;   // take the popped link, mark the node's queue link empty, post
		logic finish_write; // store payload, link behind tail, post
		logic finish_read;  // push node onto the free list, post
		logic start_link;   // read queue_next at the queue head
		logic start_fetch;  // read payload of the node after the head
		logic finish_fetch; // advance the head, post the payload
		logic post_fail;    // post a failed result
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		req_type_t req_type;
		logic      free_empty; // free head is the end marker
		logic      link_nil;   // node after the head is the end marker
		logic      idx_ok;     // node_index lies inside the pool
		logic      clr_last;   // last entry of the clearing pass
		logic      out_free;   // output register can take a result this cycle
	} status_t;

endpackage

// ----- hw/rtl/llpq_req_if.sv -----
// Request channel: valid/ready handshake carrying one request word.
interface llpq_req_if #(
	parameter int CAPACITY   = 255,
	parameter int DATA_WIDTH = 32
);
	import llpq_pkg::*;

	localparam int POOL  = CAPACITY + 1;
	localparam int IDX_W = $clog2(POOL);

	logic                  valid;
	logic                  ready;
	req_type_t             req_type;
	logic [IDX_W-1:0]      node_index;
	logic [DATA_WIDTH-1:0] write_data;

	modport source (output valid, output req_type, output node_index, output write_data,
		input ready);
	modport sink (input valid, input req_type, input node_index, input write_data,
		output ready);
endinterface

// ----- hw/rtl/llpq_rsp_if.sv -----
// Response channel: valid/ready handshake carrying one result word.
interface llpq_rsp_if #(
	parameter int CAPACITY   = 255,
	parameter int DATA_WIDTH = 32
);
	localparam int POOL  = CAPACITY + 1;
	localparam int IDX_W = $clog2(POOL);
	localparam int CNT_W = $clog2(POOL + 1);

	logic                  valid;
	logic                  ready;
	logic                  ok;
	logic [IDX_W-1:0]      result_index;
	logic [DATA_WIDTH-1:0] read_data;
	logic [CNT_W-1:0]      nodes_in_use;

	modport source (output valid, output ok, output result_index, output read_data,
		output nodes_in_use, input ready);
	modport sink (input valid, input ok, input result_index, input read_data,
		input nodes_in_use, output ready);
endinterface

// ----- hw/rtl/llpq_ram.sv -----
// Generic single-port RAM with registered read data.
module llpq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// one access per cycle; read data holds until the next read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;
endmodule

// ----- hw/rtl/llpq_ctrl.sv -----
// Controller FSM: sequences the pointer memory accesses of each request.
module llpq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  llpq_pkg::status_t  status,
	output llpq_pkg::cmd_t     cmd
);
	import llpq_pkg::*;

	state_t state_q;
	state_t state_nx;
	logic   accept;

	assign req_ready = (state_q == ST_IDLE) && status.out_free;
	assign accept    = req_valid && req_ready;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (status.clr_last) state_nx = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					case (status.req_type)
						REQ_START_WRITE: begin
							if (!status.free_empty) state_nx = ST_POP;
						end
						REQ_START_READ: state_nx = ST_LINK;
						default: state_nx = ST_IDLE;
					endcase
				end
			end
			ST_POP: begin
				if (status.out_free) state_nx = ST_IDLE;
			end
			ST_LINK: begin
				if (!status.link_nil) begin
					state_nx = ST_FETCH;
				end else if (status.out_free) begin
					state_nx = ST_IDLE;
				end
			end
			ST_FETCH: begin
				if (status.out_free) state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd = '0;
		case (state_q)
			ST_CLEAR: cmd.clr_en = 1'b1;
			ST_IDLE: begin
				if (accept) begin
					case (status.req_type)
						REQ_START_WRITE: begin
							cmd.start_pop = !status.free_empty;
							cmd.post_fail = status.free_empty;
						end
						REQ_FINISH_WRITE: begin
							cmd.finish_write = status.idx_ok;
							cmd.post_fail    = !status.idx_ok;
						end
						REQ_START_READ: cmd.start_link = 1'b1;
						REQ_FINISH_READ: begin
							cmd.finish_read = status.idx_ok;
							cmd.post_fail   = !status.idx_ok;
						end
						default: cmd = '0;
					endcase
				end
			end
			ST_POP: cmd.finish_pop = status.out_free;
			ST_LINK: begin
				cmd.start_fetch = !status.link_nil;
				cmd.post_fail   = status.link_nil && status.out_free;
			end
			ST_FETCH: cmd.finish_fetch = status.out_free;
			default: cmd = '0;
		endcase
	end
endmodule

// ----- hw/rtl/llpq_dp.sv -----
// Datapath: free/queue link memories, payload store, list pointers and result register.
module llpq_dp #(
	parameter int CAPACITY   = 255,
	parameter int DATA_WIDTH = 32
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  llpq_pkg::cmd_t                         cmd,
	output llpq_pkg::status_t                      status,
	input  llpq_pkg::req_type_t                    req_type,
	input  logic [$clog2(CAPACITY+1)-1:0]          node_index,
	input  logic [DATA_WIDTH-1:0]                  write_data,
	input  logic                                   rsp_ready,
	output logic                                   rsp_valid,
	output logic                                   ok,
	output logic [$clog2(CAPACITY+1)-1:0]          result_index,
	output logic [DATA_WIDTH-1:0]                  read_data,
	output logic [$clog2(CAPACITY+2)-1:0]          nodes_in_use
);
	import llpq_pkg::*;

	localparam int POOL  = CAPACITY + 1;
	localparam int IDX_W = $clog2(POOL);
	localparam int PTR_W = $clog2(POOL + 1);  // pointer with end marker
	localparam int CNT_W = $clog2(POOL + 1);
	localparam logic [PTR_W-1:0] NIL = PTR_W'(POOL);

	logic [PTR_W-1:0]      free_head_q;
	logic [IDX_W-1:0]      queue_head_q;
	logic [IDX_W-1:0]      queue_tail_q;
	logic [CNT_W-1:0]      free_count_q;
	logic [CNT_W-1:0]      free_count_nx;
	logic [IDX_W-1:0]      clr_q;
	logic [IDX_W-1:0]      nxt_q;
	logic                  out_valid_q;
	logic                  ok_q;
	logic [IDX_W-1:0]      result_index_q;
	logic [DATA_WIDTH-1:0] read_data_q;
	logic [CNT_W-1:0]      nodes_q;
	logic                  post;
	logic                  out_free;

	logic                  fn_we;
	logic [IDX_W-1:0]      fn_addr;
	logic [PTR_W-1:0]      fn_wdata;
	logic [PTR_W-1:0]      fn_rdata;
	logic                  qn_we;
	logic [IDX_W-1:0]      qn_addr;
	logic [PTR_W-1:0]      qn_wdata;
	logic [PTR_W-1:0]      qn_rdata;
	logic [IDX_W-1:0]      pl_addr;
	logic [DATA_WIDTH-1:0] pl_rdata;

	assign post = cmd.post_fail | cmd.finish_pop | cmd.finish_write | cmd.finish_read
		| cmd.finish_fetch;
	assign out_free = !out_valid_q || rsp_ready;

	// status back to the controller
	assign status.req_type   = req_type;
	assign status.free_empty = free_head_q >= NIL;
	assign status.link_nil   = qn_rdata >= NIL;
	assign status.idx_ok     = PTR_W'(node_index) < NIL;
	assign status.clr_last   = clr_q == IDX_W'(CAPACITY);
	assign status.out_free   = out_free;

	// free list links: clearing pass, push, pop read
	always_comb begin
		fn_we    = cmd.clr_en | cmd.finish_read;
		fn_addr  = free_head_q[IDX_W-1:0];
		fn_wdata = free_head_q;
		if (cmd.clr_en) begin
			fn_addr  = clr_q;
			fn_wdata = PTR_W'(clr_q) + PTR_W'(1);
		end else if (cmd.finish_read) begin
			fn_addr = node_index;
		end
	end

	llpq_ram #(.WIDTH(PTR_W), .DEPTH(POOL)) u_free_next (
		.clk   (clk),
		.we    (fn_we),
		.re    (cmd.start_pop),
		.addr  (fn_addr),
		.wdata (fn_wdata),
		.rdata (fn_rdata)
	);

	// queue links: clearing pass, fresh node, tail link, head read
	always_comb begin
		qn_we    = cmd.clr_en | cmd.finish_pop | cmd.finish_write;
		qn_addr  = queue_head_q;
		qn_wdata = NIL;
		if (cmd.clr_en) begin
			qn_addr = clr_q;
		end else if (cmd.finish_pop) begin
			qn_addr = free_head_q[IDX_W-1:0];
		end else if (cmd.finish_write) begin
			qn_addr  = queue_tail_q;
			qn_wdata = PTR_W'(node_index);
		end
	end

	llpq_ram #(.WIDTH(PTR_W), .DEPTH(POOL)) u_queue_next (
		.clk   (clk),
		.we    (qn_we),
		.re    (cmd.start_link),
		.addr  (qn_addr),
		.wdata (qn_wdata),
		.rdata (qn_rdata)
	);

	// payload store
	assign pl_addr = cmd.finish_write ? node_index : qn_rdata[IDX_W-1:0];

	llpq_ram #(.WIDTH(DATA_WIDTH), .DEPTH(POOL)) u_payload (
		.clk   (clk),
		.we    (cmd.finish_write),
		.re    (cmd.start_fetch),
		.addr  (pl_addr),
		.wdata (write_data),
		.rdata (pl_rdata)
	);

	// saturating free count
	always_comb begin
		free_count_nx = free_count_q;
		if (cmd.finish_pop && free_count_q != '0) begin
			free_count_nx = free_count_q - CNT_W'(1);
		end else if (cmd.finish_read && free_count_q != CNT_W'(POOL)) begin
			free_count_nx = free_count_q + CNT_W'(1);
		end
	end

	// list pointers and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q  <= PTR_W'(1);
			queue_head_q <= '0;
			queue_tail_q <= '0;
			free_count_q <= CNT_W'(CAPACITY);
			clr_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			free_count_q <= free_count_nx;
			if (cmd.clr_en) clr_q <= clr_q + IDX_W'(1);
			if (cmd.finish_pop) begin
				free_head_q <= fn_rdata;
			end else if (cmd.finish_read) begin
				free_head_q <= PTR_W'(node_index);
			end
			if (cmd.finish_write) queue_tail_q <= node_index;
			if (cmd.finish_fetch) queue_head_q <= nxt_q;
			if (post) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// node after the head, kept for the fetch cycle
	always_ff @(posedge clk) begin
		if (cmd.start_fetch) nxt_q <= qn_rdata[IDX_W-1:0];
	end

	// result word register
	always_ff @(posedge clk) begin
		if (post) begin
			ok_q           <= !cmd.post_fail;
			result_index_q <= cmd.finish_pop ? free_head_q[IDX_W-1:0]
				: (cmd.finish_fetch ? queue_head_q : '0);
			read_data_q    <= cmd.finish_fetch ? pl_rdata : '0;
			nodes_q        <= CNT_W'(POOL) - free_count_nx;
		end
	end

	assign rsp_valid    = out_valid_q;
	assign ok           = ok_q;
	assign result_index = result_index_q;
	assign read_data    = read_data_q;
	assign nodes_in_use = nodes_q;

	// a result is only posted when the output register can take it
	a_post_room: assert property (@(posedge clk) disable iff (!arst_n) post |-> out_free)
		else $error("result posted while output register busy");
	// free count stays within the pool
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		free_count_q <= CNT_W'(POOL))
		else $error("free count beyond pool size");
	// a pop only completes on a real node
	a_pop_node: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish_pop |-> free_head_q < NIL)
		else $error("pop from empty free list");
	// the fetched node is a real node
	a_fetch_node: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start_fetch |-> qn_rdata < NIL)
		else $error("fetch past end of queue");
	// at most one memory operation at a time
	a_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clr_en, cmd.start_pop, cmd.finish_pop, cmd.finish_write,
			cmd.finish_read, cmd.start_link, cmd.start_fetch, cmd.finish_fetch}))
		else $error("overlapping datapath commands");
endmodule

// ----- hw/rtl/linked_list_packet_queue.sv -----
// A result is registered: finish_write, finish_read and a refused start_write post it straight
// from the accept, a granted start_write posts it from ST_POP, and start_read from ST_LINK on an
// empty queue or from ST_FETCH otherwise; the posting states wait while the output register is
// full. One request is in flight at a time. After reset is released the link memories are
// initialized by a clearing pass over all CAPACITY+1 entries (256 by default) during which
// request.ready stays low.
module linked_list_packet_queue #(
	parameter int CAPACITY   = 255,
	parameter int DATA_WIDTH = 32
) (
	input logic      clk,
	input logic      arst_n,
	llpq_req_if.sink request,
	llpq_rsp_if.source response
);
	import llpq_pkg::*;

	cmd_t    cmd;
	status_t status;

	// request sequencing
	llpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (request.valid),
		.req_ready (request.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// lists, payload and result word
	llpq_dp #(.CAPACITY(CAPACITY), .DATA_WIDTH(DATA_WIDTH)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.req_type     (request.req_type),
		.node_index   (request.node_index),
		.write_data   (request.write_data),
		.rsp_ready    (response.ready),
		.rsp_valid    (response.valid),
		.ok           (response.ok),
		.result_index (response.result_index),
		.read_data    (response.read_data),
		.nodes_in_use (response.nodes_in_use)
	);
endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for linked_list_packet_queue: shadow node pool, scoreboard, drivers.
module testbench;
	import llpq_pkg::*;

	localparam int CAPACITY   = 255;
	localparam int DATA_WIDTH = 32;
	localparam int POOL       = CAPACITY + 1;
	localparam logic [8:0] NIL = 9'(POOL);

	// one response word as seen on the response channel
	typedef struct packed {
		logic        ok;
		logic [7:0]  result_index;
		logic [31:0] read_data;
		logic [8:0]  nodes_in_use;
	} rsp_word_t;

	// shadow copy of the node pool plus the words still owed by the block
	class pool_scoreboard;
		logic [8:0]  free_link [POOL];
		logic [8:0]  queue_link [POOL];
		logic [31:0] payload [POOL];
		logic [8:0]  free_head;
		logic [7:0]  queue_head;
		logic [7:0]  queue_tail;
		int          free_count;
		rsp_word_t   owed_words [$];
		int          errors;
		int          req_count [4];
		int          refused;
		int          peak_in_use;

		function new();
			for (int i = 0; i < POOL; i++) begin
				free_link[i]  = 9'(i + 1);
				queue_link[i] = NIL;
				payload[i]    = '0;
			end
			foreach (req_count[i])
				req_count[i] = 0;
			free_head   = 9'd1;
			queue_head  = 8'd0;
			queue_tail  = 8'd0;
			free_count  = CAPACITY;
			errors      = 0;
			refused     = 0;
			peak_in_use = 0;
		endfunction

		// apply one accepted request to the shadow pool, queue and return the response it owes
		function rsp_word_t note_request(req_type_t rt, logic [7:0] idx, logic [31:0] data);
			rsp_word_t  r;
			logic [8:0] nxt;
			logic [7:0] node;
			r = '0;
			// an 8-bit index always lies inside the 256-node pool
			case (rt)
				REQ_START_WRITE: begin
					if (free_head < NIL) begin
						node             = free_head[7:0];
						free_head        = free_link[node];
						if (free_count > 0)
							free_count--;
						queue_link[node] = NIL;
						r.ok             = 1'b1;
						r.result_index   = node;
					end
				end
				REQ_FINISH_WRITE: begin
					payload[idx]           = data;
					queue_link[queue_tail] = {1'b0, idx};
					queue_tail             = idx;
					r.ok                   = 1'b1;
				end
				REQ_START_READ: begin
					nxt = queue_link[queue_head];
					if (nxt < NIL) begin
						r.read_data    = payload[nxt[7:0]];
						r.result_index = queue_head;
						queue_head     = nxt[7:0];
						r.ok           = 1'b1;
					end
				end
				default: begin
					free_link[idx] = free_head;
					free_head      = {1'b0, idx};
					if (free_count < POOL)
						free_count++;
					r.ok = 1'b1;
				end
			endcase
			r.nodes_in_use = 9'(POOL - free_count);
			req_count[rt]++;
			if (!r.ok)
				refused++;
			if (r.nodes_in_use > peak_in_use)
				peak_in_use = r.nodes_in_use;
			owed_words.push_back(r);
			return r;
		endfunction

		function void compare(string field, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				errors++;
				if (errors <= 25)
					$display("%0t: %s expected %0h got %0h", $time, field, want, got);
			end
		endfunction

		// compare one accepted response word with the oldest owed word
		function void check_result(rsp_word_t got);
			rsp_word_t want;
			if (owed_words.size() == 0) begin
				errors++;
				if (errors <= 25)
					$display("%0t: response word with nothing owed: expected none got %0h",
						$time, got);
				return;
			end
			want = owed_words.pop_front();
			compare("ok", want.ok, got.ok);
			compare("result_index", want.result_index, got.result_index);
			compare("read_data", want.read_data, got.read_data);
			compare("nodes_in_use", want.nodes_in_use, got.nodes_in_use);
		endfunction

		function int pending();
			return owed_words.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	llpq_req_if #(.CAPACITY(CAPACITY), .DATA_WIDTH(DATA_WIDTH)) req_ch ();
	llpq_rsp_if #(.CAPACITY(CAPACITY), .DATA_WIDTH(DATA_WIDTH)) rsp_ch ();

	linked_list_packet_queue #(.CAPACITY(CAPACITY), .DATA_WIDTH(DATA_WIDTH)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.request  (req_ch),
		.response (rsp_ch)
	);

	pool_scoreboard sb;
	rsp_word_t      last_rsp;
	int             tx_idle_pct;
	int             rx_idle_pct;
	logic [7:0]     claimed [$];  // allocated, not yet finished
	logic [7:0]     spent [$];    // old heads handed back by start_read

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// receiver stalls
	always @(negedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// response monitor
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			sb.check_result({rsp_ch.ok, rsp_ch.result_index, rsp_ch.read_data,
				rsp_ch.nodes_in_use});
	end

	function automatic logic [31:0] rand_payload();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	// drive one request word; entered and left at a falling edge
	task automatic issue(req_type_t rt, logic [7:0] idx, logic [31:0] data);
		while ($urandom_range(99) < tx_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.req_type   <= rt;
		req_ch.node_index <= idx;
		req_ch.write_data <= data;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		last_rsp = sb.note_request(rt, idx, data);
		// track nodes so later words can finish and free them
		if (last_rsp.ok && rt == REQ_START_WRITE)
			claimed.push_back(last_rsp.result_index);
		if (last_rsp.ok && rt == REQ_START_READ)
			spent.push_back(last_rsp.result_index);
		@(negedge clk);
	endtask

	// hold off the sender until every owed word has come back, or until max_cycles runs out
	task automatic drain(int max_cycles);
		int n;
		n = 0;
		req_ch.valid <= 1'b0;
		@(negedge clk);
		while (sb.pending() > 0 && n < max_cycles) begin
			@(negedge clk);
			n++;
		end
	endtask

	// mostly well-formed traffic with a drifting write/read mix, a little noise
	task automatic run_phase(int items, int tx_pct, int rx_pct);
		int         bias;
		int         k;
		logic [7:0] idx;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		bias        = 50;
		for (int n = 0; n < items; n++) begin
			if (n % 60 == 0) begin
				case ($urandom_range(2))
					0: bias = 12;
					1: bias = 50;
					default: bias = 88;
				endcase
			end
			if ($urandom_range(99) < 3) begin
				issue(req_type_t'($urandom_range(3)), 8'($urandom), $urandom);
			end else if ($urandom_range(99) < bias) begin
				if (claimed.size() > 0 && $urandom_range(1)) begin
					k   = $urandom_range(claimed.size() - 1);
					idx = claimed[k];
					claimed.delete(k);
					issue(REQ_FINISH_WRITE, idx, rand_payload());
				end else begin
					issue(REQ_START_WRITE, 8'($urandom), $urandom);
				end
			end else begin
				if (spent.size() > 0 && $urandom_range(1)) begin
					k   = $urandom_range(spent.size() - 1);
					idx = spent[k];
					spent.delete(k);
					issue(REQ_FINISH_READ, idx, $urandom);
				end else begin
					issue(REQ_START_READ, 8'($urandom), $urandom);
				end
			end
		end
		drain(20000);
	endtask

	// main sequence
	initial begin
		logic [7:0] victim;
		req_ch.valid      = 1'b0;
		req_ch.req_type   = REQ_START_WRITE;
		req_ch.node_index = '0;
		req_ch.write_data = '0;
		arst_n            = 1'b0;
		tx_idle_pct       = 0;
		rx_idle_pct       = 0;
		sb                = new();
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty reads, extremes of payload, out-of-order finish, LIFO reuse
		issue(REQ_START_READ, 8'hFF, '1);
		issue(REQ_START_WRITE, 8'h00, '0);
		issue(REQ_FINISH_WRITE, claimed.pop_front(), '0);
		issue(REQ_START_WRITE, 8'hFF, '1);
		issue(REQ_FINISH_WRITE, claimed.pop_front(), '1);
		issue(REQ_START_WRITE, 8'h5A, 32'h1234_5678);
		issue(REQ_FINISH_WRITE, claimed.pop_front(), 32'h8000_0001);
		repeat (4) issue(REQ_START_READ, 8'h00, '0);
		repeat (3) issue(REQ_FINISH_READ, spent.pop_front(), '0);
		repeat (2) issue(REQ_START_WRITE, 8'h00, '0);
		issue(REQ_FINISH_WRITE, claimed.pop_back(), 32'h5555_5555);
		issue(REQ_FINISH_WRITE, claimed.pop_front(), 32'hAAAA_AAAA);
		repeat (2) issue(REQ_START_READ, 8'h00, '0);
		repeat (2) issue(REQ_FINISH_READ, spent.pop_front(), '0);
		drain(2000);

		// random traffic under three stall mixes
		run_phase(340, 7, 87);
		run_phase(340, 87, 7);
		run_phase(340, 0, 0);

		// fill the pool until start_write is refused
		for (int n = 0; n < 300; n++) begin
			issue(REQ_START_WRITE, 8'($urandom), $urandom);
			if (!last_rsp.ok)
				break;
		end

		// double free: node links to itself, pops keep returning it past a zero count
		victim = (claimed.size() > 0) ? claimed.pop_back() : 8'h07;
		repeat (2) issue(REQ_FINISH_READ, victim, '0);
		repeat (3) issue(REQ_START_WRITE, 8'h00, '0);

		// finishing the dummy node closes the queue into a loop
		issue(REQ_FINISH_WRITE, 8'h00, rand_payload());
		repeat (3) issue(REQ_START_READ, 8'h00, '0);

		// free every node and one more, so the free count pins at the pool size
		for (int n = 0; n < POOL; n++)
			issue(REQ_FINISH_READ, 8'(n), '0);
		issue(REQ_FINISH_READ, 8'hA5, '0);
		repeat (2) issue(REQ_START_WRITE, 8'h00, '0);
		drain(20000);
		repeat (10) @(negedge clk);

		if (sb.pending() > 0) begin
			sb.errors++;
			$display("%0t: %0d expected response words never arrived", $time, sb.pending());
		end
		$display("run: %0d start_write, %0d finish_write, %0d start_read, %0d finish_read, %0d refused",
			sb.req_count[REQ_START_WRITE], sb.req_count[REQ_FINISH_WRITE],
			sb.req_count[REQ_START_READ], sb.req_count[REQ_FINISH_READ], sb.refused);
		$display("stalls on each side and none; peak %0d nodes in use; double free and over-free",
			sb.peak_in_use);
		if (sb.errors == 0) begin
			$display("linked_list_packet_queue: match");
		end else begin
			$display("linked_list_packet_queue: mismatch");
		end
		$finish;
	end

	// watchdog
	initial begin
		#3000000;
		$display("linked_list_packet_queue: mismatch");
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/llpq_pkg.sv
hw/rtl/llpq_req_if.sv
hw/rtl/llpq_rsp_if.sv
hw/rtl/llpq_ram.sv
hw/rtl/llpq_ctrl.sv
hw/rtl/llpq_dp.sv
hw/rtl/linked_list_packet_queue.sv
sim/testbench.sv
